// ----- sv/wcrd_pkg.sv -----
package wcrd_pkg;

   // Default sizes handed to the top level
   localparam int DEF_ID_BITS      = 32;
   localparam int DEF_COUNTER_BITS = 32;

   // Width of every wide field on the channels and the register port
   localparam int FIELD_W   = 32;
   localparam int CSR_IDX_W = 1;

   // Xorshift shift amounts
   localparam int XS_SHL_A = 13;
   localparam int XS_SHR   = 17;
   localparam int XS_SHL_B = 5;

   // Register reset values
   localparam logic [FIELD_W-1:0] WINDOW_RESET = 32'd16;
   localparam logic [FIELD_W-1:0] SEED_RESET   = 32'd1;

   typedef enum logic [1:0] {
      OUT_IDLE,
      OUT_WINDOW_BLOCKED,
      OUT_ENGINE_BLOCKED,
      OUT_DISPATCHED
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE,
      CSR_RANDOM_SEED
   } csr_index_type;

   // One offered item as held in the input register
   typedef struct packed {
      logic               item_valid;
      logic [FIELD_W-1:0] item_id;
      logic [FIELD_W-1:0] window_base;
      logic               engine0_ready;
      logic               engine1_ready;
   } wcrd_req_type;

   // One result beat as held in the output register
   typedef struct packed {
      logic               accept;
      logic               engine0_valid;
      logic               engine1_valid;
      logic               chosen_engine;
      outcome_type        outcome;
      logic               random_used;
      logic [FIELD_W-1:0] random_before;
      logic [FIELD_W-1:0] window_blocked_count;
      logic [FIELD_W-1:0] window_blocked_ready_count;
      logic [FIELD_W-1:0] engine_blocked_count;
      logic [FIELD_W-1:0] dispatched_count;
      logic [FIELD_W-1:0] random_choice_count;
   } wcrd_rsp_type;

   // 32-bit xorshift, shifts 13 / 17 / 5
   function automatic logic [FIELD_W-1:0] xorshift_next(input logic [FIELD_W-1:0] s);
      logic [FIELD_W-1:0] t;
      t = s ^ (s << XS_SHL_A);
      t = t ^ (t >> XS_SHR);
      t = t ^ (t << XS_SHL_B);
      return t;
   endfunction

endpackage

// ----- sv/wcrd_req_if.sv -----
interface wcrd_req_if import wcrd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               item_valid;
   logic [FIELD_W-1:0] item_id;
   logic [FIELD_W-1:0] window_base;
   logic               engine0_ready;
   logic               engine1_ready;

   modport source (
      output valid, item_valid, item_id, window_base, engine0_ready, engine1_ready,
      input  ready
   );
   modport sink (
      input  valid, item_valid, item_id, window_base, engine0_ready, engine1_ready,
      output ready
   );
endinterface

// ----- sv/wcrd_rsp_if.sv -----
interface wcrd_rsp_if import wcrd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               accept;
   logic               engine0_valid;
   logic               engine1_valid;
   logic               chosen_engine;
   outcome_type        outcome;
   logic               random_used;
   logic [FIELD_W-1:0] random_before;
   logic [FIELD_W-1:0] window_blocked_count;
   logic [FIELD_W-1:0] window_blocked_ready_count;
   logic [FIELD_W-1:0] engine_blocked_count;
   logic [FIELD_W-1:0] dispatched_count;
   logic [FIELD_W-1:0] random_choice_count;

   modport source (
      output valid, accept, engine0_valid, engine1_valid, chosen_engine, outcome,
             random_used, random_before, window_blocked_count,
             window_blocked_ready_count, engine_blocked_count, dispatched_count,
             random_choice_count,
      input  ready
   );
   modport sink (
      input  valid, accept, engine0_valid, engine1_valid, chosen_engine, outcome,
             random_used, random_before, window_blocked_count,
             window_blocked_ready_count, engine_blocked_count, dispatched_count,
             random_choice_count,
      output ready
   );
endinterface

// ----- sv/window_credit_random_dispatcher.sv -----
// Channel   Direction  Handshake         Carries
// req_chan  in         valid / ready     item_valid, item_id, window_base, engine readies
// rsp_chan  out        valid / ready     accept, engine valids, outcome, random state, counts
// csr_*     in         csr_we only       csr_index, csr_wdata (window size, random seed)
//
// One beat per clock in and out unless rsp_chan stalls; beats pass the input, then the output register.
// Throughput is set by the single decision stage between the input and output registers.
// Reset (synchronous, high) empties both registers, loads window 16 and random state 1, clears the counters.
// A stalled rsp_chan holds its beat; the input register still takes one more beat if it is empty.
// The counters update as a beat leaves the decision stage; the random state too if it broke a tie.
module window_credit_random_dispatcher import wcrd_pkg::*; #(
   parameter int ID_BITS      = DEF_ID_BITS,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   wcrd_req_if.sink             req_chan,
   wcrd_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   localparam int IdW  = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
   localparam int CntW = (COUNTER_BITS < FIELD_W) ? COUNTER_BITS : FIELD_W;

   // Registers
   logic                    stage_valid_ff, stage_valid_in;
   wcrd_req_type            stage_ff, stage_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   wcrd_rsp_type            rsp_ff, rsp_in;
   logic [FIELD_W-1:0]      window_size_ff, window_size_in;
   logic [FIELD_W-1:0]      random_state_ff, random_state_in;
   logic [COUNTER_BITS-1:0] wb_cnt_ff, wb_cnt_in;
   logic [COUNTER_BITS-1:0] wbr_cnt_ff, wbr_cnt_in;
   logic [COUNTER_BITS-1:0] eb_cnt_ff, eb_cnt_in;
   logic [COUNTER_BITS-1:0] disp_cnt_ff, disp_cnt_in;
   logic [COUNTER_BITS-1:0] rnd_cnt_ff, rnd_cnt_in;

   logic               advance;
   logic               req_take;
   logic [IdW-1:0]     id_w;
   logic [IdW-1:0]     base_w;
   logic [IdW-1:0]     id_diff;
   logic               credit;
   logic               both_ready;
   logic               sel;
   logic               sel_ready;
   logic               acc;
   logic               rnd_used;
   outcome_type        outcome;
   logic [FIELD_W-1:0] seed_val;
   csr_index_type      csr_idx;

   // Handshake: decision stage moves when the output register is free or draining
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_take  = req_chan.valid && req_chan.ready;

   // Input register
   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_in.item_valid    = req_chan.item_valid;
         stage_in.item_id       = req_chan.item_id;
         stage_in.window_base   = req_chan.window_base;
         stage_in.engine0_ready = req_chan.engine0_ready;
         stage_in.engine1_ready = req_chan.engine1_ready;
         stage_valid_in         = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   // Credit check and engine choice
   assign id_w       = stage_ff.item_id[IdW-1:0];
   assign base_w     = stage_ff.window_base[IdW-1:0];
   assign id_diff    = id_w - base_w;
   assign credit     = (id_w >= base_w) && (FIELD_W'(id_diff) < window_size_ff);
   assign both_ready = stage_ff.engine0_ready && stage_ff.engine1_ready;
   assign sel        = both_ready ? random_state_ff[0] : !stage_ff.engine0_ready;
   assign sel_ready  = sel ? stage_ff.engine1_ready : stage_ff.engine0_ready;
   assign acc        = credit && sel_ready;

   // Outcome and statistics
   always_comb begin
      wb_cnt_in   = wb_cnt_ff;
      wbr_cnt_in  = wbr_cnt_ff;
      eb_cnt_in   = eb_cnt_ff;
      disp_cnt_in = disp_cnt_ff;
      rnd_cnt_in  = rnd_cnt_ff;
      outcome     = OUT_IDLE;
      rnd_used    = 1'b0;
      if (stage_ff.item_valid) begin
         if (!credit) begin
            outcome   = OUT_WINDOW_BLOCKED;
            wb_cnt_in = wb_cnt_ff + 1'b1;
            if (stage_ff.engine0_ready || stage_ff.engine1_ready) begin
               wbr_cnt_in = wbr_cnt_ff + 1'b1;
            end
         end else if (!sel_ready) begin
            outcome   = OUT_ENGINE_BLOCKED;
            eb_cnt_in = eb_cnt_ff + 1'b1;
         end else begin
            outcome     = OUT_DISPATCHED;
            disp_cnt_in = disp_cnt_ff + 1'b1;
            if (both_ready) begin
               rnd_used   = 1'b1;
               rnd_cnt_in = rnd_cnt_ff + 1'b1;
            end
         end
      end
   end

   // Result beat
   always_comb begin
      rsp_in.accept                     = acc;
      rsp_in.engine0_valid              = stage_ff.item_valid && acc && !sel;
      rsp_in.engine1_valid              = stage_ff.item_valid && acc && sel;
      rsp_in.chosen_engine              = sel;
      rsp_in.outcome                    = outcome;
      rsp_in.random_used                = rnd_used;
      rsp_in.random_before              = random_state_ff;
      rsp_in.window_blocked_count       = FIELD_W'(wb_cnt_in[CntW-1:0]);
      rsp_in.window_blocked_ready_count = FIELD_W'(wbr_cnt_in[CntW-1:0]);
      rsp_in.engine_blocked_count       = FIELD_W'(eb_cnt_in[CntW-1:0]);
      rsp_in.dispatched_count           = FIELD_W'(disp_cnt_in[CntW-1:0]);
      rsp_in.random_choice_count        = FIELD_W'(rnd_cnt_in[CntW-1:0]);
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration writes and random state
   assign seed_val = (csr_wdata == '0) ? SEED_RESET : csr_wdata;
   assign csr_idx  = csr_index_type'(csr_index);

   always_comb begin
      window_size_in  = window_size_ff;
      random_state_in = random_state_ff;
      if (advance && rnd_used) begin
         random_state_in = xorshift_next(random_state_ff);
      end
      if (csr_we) begin
         case (csr_idx)
            CSR_WINDOW_SIZE: window_size_in  = csr_wdata;
            CSR_RANDOM_SEED: random_state_in = seed_val;
            default:         window_size_in  = window_size_ff;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         window_size_ff  <= WINDOW_RESET;
         random_state_ff <= SEED_RESET;
         wb_cnt_ff       <= '0;
         wbr_cnt_ff      <= '0;
         eb_cnt_ff       <= '0;
         disp_cnt_ff     <= '0;
         rnd_cnt_ff      <= '0;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         window_size_ff  <= window_size_in;
         random_state_ff <= random_state_in;
         if (advance) begin
            wb_cnt_ff   <= wb_cnt_in;
            wbr_cnt_ff  <= wbr_cnt_in;
            eb_cnt_ff   <= eb_cnt_in;
            disp_cnt_ff <= disp_cnt_in;
            rnd_cnt_ff  <= rnd_cnt_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Output channel
   assign rsp_chan.valid                      = rsp_valid_ff;
   assign rsp_chan.accept                     = rsp_ff.accept;
   assign rsp_chan.engine0_valid              = rsp_ff.engine0_valid;
   assign rsp_chan.engine1_valid              = rsp_ff.engine1_valid;
   assign rsp_chan.chosen_engine              = rsp_ff.chosen_engine;
   assign rsp_chan.outcome                    = rsp_ff.outcome;
   assign rsp_chan.random_used                = rsp_ff.random_used;
   assign rsp_chan.random_before              = rsp_ff.random_before;
   assign rsp_chan.window_blocked_count       = rsp_ff.window_blocked_count;
   assign rsp_chan.window_blocked_ready_count = rsp_ff.window_blocked_ready_count;
   assign rsp_chan.engine_blocked_count       = rsp_ff.engine_blocked_count;
   assign rsp_chan.dispatched_count           = rsp_ff.dispatched_count;
   assign rsp_chan.random_choice_count        = rsp_ff.random_choice_count;

endmodule

// ----- sv/wcrd_checker.sv -----
module wcrd_checker import wcrd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               engine0_valid,
   input logic               engine1_valid,
   input logic               chosen_engine,
   input outcome_type        outcome,
   input logic               random_used,
   input logic [FIELD_W-1:0] random_before,
   input logic [FIELD_W-1:0] dispatched_count
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(dispatched_count)
                                  && $stable(random_before) && $stable(outcome))
      else $error("result beat changed while stalled");

   // Exactly one engine strobe on a dispatch, none otherwise
   a_one_engine: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(engine0_valid && engine1_valid)
                    && ((engine0_valid || engine1_valid) == (outcome == OUT_DISPATCHED)))
      else $error("engine strobes disagree with outcome");

   // A random tie break is a dispatch steered by the low random bit
   a_random_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && random_used |-> outcome == OUT_DISPATCHED
                                   && chosen_engine == random_before[0])
      else $error("random tie break inconsistent");

   // Random state never reaches zero
   a_random_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> random_before != '0)
      else $error("random state is zero");

   // Nothing leaves straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind window_credit_random_dispatcher wcrd_checker u_wcrd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .engine0_valid    (rsp_chan.engine0_valid),
   .engine1_valid    (rsp_chan.engine1_valid),
   .chosen_engine    (rsp_chan.chosen_engine),
   .outcome          (rsp_chan.outcome),
   .random_used      (rsp_chan.random_used),
   .random_before    (rsp_chan.random_before),
   .dispatched_count (rsp_chan.dispatched_count)
);
